/* sv/segx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_pkg
// Shared types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segx_pkg;

    localparam int TOL_WIDTH = 16;

    // control that travels beside the divider data
    typedef struct packed {
        logic valid;
        logic hit;
        logic col;
        logic neg_x;
        logic neg_y;
    } segx_side_t;

endpackage

/* sv/segment_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection
// Pipelined 2D segment intersection test with collinear overlap handling.
// ----------------------------------------------------------------------------
// One transaction (a pair of segments) is taken every clock cycle; busy is
// always low. Each result appears on the result ports for one cycle with done
// high. The receiver cannot stall. The point division is a restoring divider
// with one quotient bit per pipeline stage, COORD_WIDTH stages, behind seven
// stages of differences, cross/dot products, path selection and numerator
// forming. collinear_tolerance is written through cfg_we/cfg_data and must
// only change while no transaction is in flight.
module segment_intersection
    import segx_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic [TOL_WIDTH-1:0]          cfg_data,
    input  logic signed [COORD_WIDTH-1:0] a_start_x,
    input  logic signed [COORD_WIDTH-1:0] a_start_y,
    input  logic signed [COORD_WIDTH-1:0] a_end_x,
    input  logic signed [COORD_WIDTH-1:0] a_end_y,
    input  logic signed [COORD_WIDTH-1:0] b_start_x,
    input  logic signed [COORD_WIDTH-1:0] b_start_y,
    input  logic signed [COORD_WIDTH-1:0] b_end_x,
    input  logic signed [COORD_WIDTH-1:0] b_end_y,
    output logic                          done,
    output logic                          hit,
    output logic                          collinear,
    output logic signed [COORD_WIDTH-1:0] hit_x,
    output logic signed [COORD_WIDTH-1:0] hit_y
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;          // coordinate differences
    localparam int PW  = 2 * DW;          // single products
    localparam int XW  = 2 * CW + 4;      // cross/dot sums, denominators
    localparam int NW  = 3 * CW + 4;      // point numerators
    localparam int QW  = CW;              // quotient magnitude bits
    localparam int LAT = QW + 8;

    logic start_acc;
    assign start_acc = start && !busy;
    assign busy      = 1'b0;

    logic [TOL_WIDTH-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_data;
    end

    // stage 1: differences
    logic                 s1_valid_reg;
    logic signed [CW-1:0] s1_px_reg, s1_py_reg;
    logic signed [DW-1:0] s1_rx_reg, s1_ry_reg, s1_sx_reg, s1_sy_reg, s1_wx_reg, s1_wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start_acc;
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg <= a_start_x;
        s1_py_reg <= a_start_y;
        s1_rx_reg <= DW'(a_end_x) - DW'(a_start_x);
        s1_ry_reg <= DW'(a_end_y) - DW'(a_start_y);
        s1_sx_reg <= DW'(b_end_x) - DW'(b_start_x);
        s1_sy_reg <= DW'(b_end_y) - DW'(b_start_y);
        s1_wx_reg <= DW'(b_start_x) - DW'(a_start_x);
        s1_wy_reg <= DW'(b_start_y) - DW'(a_start_y);
    end

    // stage 2: products
    logic                 s2_valid_reg;
    logic signed [CW-1:0] s2_px_reg, s2_py_reg;
    logic signed [DW-1:0] s2_rx_reg, s2_ry_reg;
    logic signed [PW-1:0] s2_rs_a_reg, s2_rs_b_reg, s2_wr_a_reg, s2_wr_b_reg;
    logic signed [PW-1:0] s2_ws_a_reg, s2_ws_b_reg, s2_rr_a_reg, s2_rr_b_reg;
    logic signed [PW-1:0] s2_wd_a_reg, s2_wd_b_reg, s2_sd_a_reg, s2_sd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_px_reg   <= s1_px_reg;
        s2_py_reg   <= s1_py_reg;
        s2_rx_reg   <= s1_rx_reg;
        s2_ry_reg   <= s1_ry_reg;
        s2_rs_a_reg <= PW'(s1_rx_reg) * PW'(s1_sy_reg);
        s2_rs_b_reg <= PW'(s1_ry_reg) * PW'(s1_sx_reg);
        s2_wr_a_reg <= PW'(s1_wx_reg) * PW'(s1_ry_reg);
        s2_wr_b_reg <= PW'(s1_wy_reg) * PW'(s1_rx_reg);
        s2_ws_a_reg <= PW'(s1_wx_reg) * PW'(s1_sy_reg);
        s2_ws_b_reg <= PW'(s1_wy_reg) * PW'(s1_sx_reg);
        s2_rr_a_reg <= PW'(s1_rx_reg) * PW'(s1_rx_reg);
        s2_rr_b_reg <= PW'(s1_ry_reg) * PW'(s1_ry_reg);
        s2_wd_a_reg <= PW'(s1_wx_reg) * PW'(s1_rx_reg);
        s2_wd_b_reg <= PW'(s1_wy_reg) * PW'(s1_ry_reg);
        s2_sd_a_reg <= PW'(s1_sx_reg) * PW'(s1_rx_reg);
        s2_sd_b_reg <= PW'(s1_sy_reg) * PW'(s1_ry_reg);
    end

    // stage 3: cross and dot products
    logic                 s3_valid_reg;
    logic signed [CW-1:0] s3_px_reg, s3_py_reg;
    logic signed [DW-1:0] s3_rx_reg, s3_ry_reg;
    logic signed [XW-1:0] s3_c_reg, s3_cr_reg, s3_cs_reg, s3_rr_reg, s3_n0_reg, s3_sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_px_reg <= s2_px_reg;
        s3_py_reg <= s2_py_reg;
        s3_rx_reg <= s2_rx_reg;
        s3_ry_reg <= s2_ry_reg;
        s3_c_reg  <= XW'(s2_rs_a_reg) - XW'(s2_rs_b_reg);
        s3_cr_reg <= XW'(s2_wr_a_reg) - XW'(s2_wr_b_reg);
        s3_cs_reg <= XW'(s2_ws_a_reg) - XW'(s2_ws_b_reg);
        s3_rr_reg <= XW'(s2_rr_a_reg) + XW'(s2_rr_b_reg);
        s3_n0_reg <= XW'(s2_wd_a_reg) + XW'(s2_wd_b_reg);
        s3_sr_reg <= XW'(s2_sd_a_reg) + XW'(s2_sd_b_reg);
    end

    // stage 4: magnitudes, sign normalization, far end of projected B
    logic                 s4_valid_reg;
    logic signed [CW-1:0] s4_px_reg, s4_py_reg;
    logic signed [DW-1:0] s4_rx_reg, s4_ry_reg;
    logic signed [XW-1:0] s4_acr_reg, s4_acs_reg, s4_dn_reg, s4_tn_reg, s4_un_reg;
    logic signed [XW-1:0] s4_rr_reg, s4_n0_reg, s4_n1_reg;
    logic                 s4_cnz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_px_reg  <= s3_px_reg;
        s4_py_reg  <= s3_py_reg;
        s4_rx_reg  <= s3_rx_reg;
        s4_ry_reg  <= s3_ry_reg;
        s4_acr_reg <= s3_cr_reg[XW-1] ? -s3_cr_reg : s3_cr_reg;
        s4_acs_reg <= s3_cs_reg[XW-1] ? -s3_cs_reg : s3_cs_reg;
        s4_dn_reg  <= s3_c_reg[XW-1] ? -s3_c_reg : s3_c_reg;
        s4_tn_reg  <= s3_c_reg[XW-1] ? -s3_cs_reg : s3_cs_reg;
        s4_un_reg  <= s3_c_reg[XW-1] ? -s3_cr_reg : s3_cr_reg;
        s4_cnz_reg <= (s3_c_reg != '0);
        s4_rr_reg  <= s3_rr_reg;
        s4_n0_reg  <= s3_n0_reg;
        s4_n1_reg  <= s3_n0_reg + s3_sr_reg;
    end

    // stage 5: path decision, pick numerator and denominator
    logic signed [XW-1:0] tol_x, nmin, nmax, sel_d, sel_n;
    logic                 col_c, hit_c;

    always_comb
    begin
        tol_x = XW'({1'b0, tol_reg});
        col_c = (s4_acr_reg <= tol_x) && (s4_acs_reg <= tol_x);
        nmin  = (s4_n0_reg < s4_n1_reg) ? s4_n0_reg : s4_n1_reg;
        nmax  = (s4_n0_reg < s4_n1_reg) ? s4_n1_reg : s4_n0_reg;
        if (col_c)
        begin
            hit_c = (s4_rr_reg > 0) && (nmax >= 0) && (nmin <= s4_rr_reg);
            sel_d = s4_rr_reg;
            sel_n = nmin[XW-1] ? '0 : nmin;
        end
        else
        begin
            hit_c = s4_cnz_reg && (s4_tn_reg >= 0) && (s4_tn_reg <= s4_dn_reg)
                    && (s4_un_reg >= 0) && (s4_un_reg <= s4_dn_reg);
            sel_d = s4_dn_reg;
            sel_n = s4_tn_reg;
        end
    end

    logic                 s5_valid_reg, s5_hit_reg, s5_col_reg;
    logic signed [CW-1:0] s5_px_reg, s5_py_reg;
    logic signed [DW-1:0] s5_rx_reg, s5_ry_reg;
    logic signed [XW-1:0] s5_d_reg, s5_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_hit_reg <= hit_c;
        s5_col_reg <= col_c;
        s5_px_reg  <= s4_px_reg;
        s5_py_reg  <= s4_py_reg;
        s5_rx_reg  <= s4_rx_reg;
        s5_ry_reg  <= s4_ry_reg;
        s5_d_reg   <= sel_d;
        s5_n_reg   <= sel_n;
    end

    // stage 6: numerator products p*d and n*r
    logic                 s6_valid_reg, s6_hit_reg, s6_col_reg;
    logic signed [XW-1:0] s6_d_reg;
    logic signed [NW-1:0] s6_pdx_reg, s6_pdy_reg, s6_nrx_reg, s6_nry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_hit_reg <= s5_hit_reg;
        s6_col_reg <= s5_col_reg;
        s6_d_reg   <= s5_d_reg;
        s6_pdx_reg <= NW'(s5_px_reg) * NW'(s5_d_reg);
        s6_pdy_reg <= NW'(s5_py_reg) * NW'(s5_d_reg);
        s6_nrx_reg <= NW'(s5_n_reg) * NW'(s5_rx_reg);
        s6_nry_reg <= NW'(s5_n_reg) * NW'(s5_ry_reg);
    end

    // stage 7 and divider: entry 0 holds the magnitudes, one quotient bit per entry
    logic signed [NW-1:0] num_x, num_y;
    assign num_x = s6_pdx_reg + s6_nrx_reg;
    assign num_y = s6_pdy_reg + s6_nry_reg;

    segx_side_t      side_reg [0:QW];
    logic [NW-1:0]   rem_x_reg [0:QW];
    logic [NW-1:0]   rem_y_reg [0:QW];
    logic [XW-1:0]   div_reg   [0:QW];
    logic [QW-1:0]   q_x_reg   [0:QW];
    logic [QW-1:0]   q_y_reg   [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg[0] <= '0;
        else
            side_reg[0] <= '{valid: s6_valid_reg, hit: s6_hit_reg, col: s6_col_reg,
                             neg_x: num_x[NW-1], neg_y: num_y[NW-1]};
    end

    always_ff @(posedge clk)
    begin
        rem_x_reg[0] <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
        rem_y_reg[0] <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
        div_reg[0]   <= s6_d_reg;
        q_x_reg[0]   <= '0;
        q_y_reg[0]   <= '0;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = QW - 1 - k;
        logic [NW-1:0] dsh;
        logic          ge_x, ge_y;

        assign dsh  = NW'(div_reg[k]) << B;
        assign ge_x = (rem_x_reg[k] >= dsh);
        assign ge_y = (rem_y_reg[k] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[k+1] <= '0;
            else
                side_reg[k+1] <= side_reg[k];
        end

        always_ff @(posedge clk)
        begin
            div_reg[k+1]   <= div_reg[k];
            rem_x_reg[k+1] <= ge_x ? rem_x_reg[k] - dsh : rem_x_reg[k];
            rem_y_reg[k+1] <= ge_y ? rem_y_reg[k] - dsh : rem_y_reg[k];
            q_x_reg[k+1]   <= q_x_reg[k] | (QW'(ge_x) << B);
            q_y_reg[k+1]   <= q_y_reg[k] | (QW'(ge_y) << B);
        end
    end

    // output register
    logic                 done_reg, hit_reg, col_reg;
    logic signed [CW-1:0] hx_reg, hy_reg;
    logic signed [CW-1:0] hx_next, hy_next;

    always_comb
    begin
        hx_next = side_reg[QW].neg_x ? CW'(-q_x_reg[QW]) : CW'(q_x_reg[QW]);
        hy_next = side_reg[QW].neg_y ? CW'(-q_y_reg[QW]) : CW'(q_y_reg[QW]);
        if (!side_reg[QW].hit)
        begin
            hx_next = '0;
            hy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= side_reg[QW].valid;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= side_reg[QW].hit;
        col_reg <= side_reg[QW].col;
        hx_reg  <= hx_next;
        hy_reg  <= hy_next;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign collinear = col_reg;
    assign hit_x     = hx_reg;
    assign hit_y     = hy_reg;

    // every transaction gives exactly one result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start_acc |-> ##LAT done)
        else $error("result missing after transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start_acc, LAT))
        else $error("result without transaction");

    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> (hit_x == '0) && (hit_y == '0))
        else $error("nonzero point without hit");

endmodule
